/* rtl/pse_pkg.sv */
// Package for the postfix stack evaluator: opcode codes, sign and limit constants and the queue entry type.
// No dependencies.
`default_nettype none
package pse_pkg;
    typedef enum logic [2:0] {
        OP_NUM = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_END = 3'd5
    } t_opcode;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LIMIT_Q  = 64'd1677721600000000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] value;
    } t_token;
endpackage
`default_nettype wire

/* rtl/pse_front.sv */
// Front part: accepts tokens, drops unused opcodes, queues the rest (two entries).
// Depends on pse_pkg.
`default_nettype none
module pse_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [2:0]       i_opcode,
    input  wire  [63:0]      i_value,
    output logic             o_tok_valid,
    input  wire              i_tok_ready,
    output pse_pkg::t_token  o_tok
);
    pse_pkg::t_token r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       push, pop, keep;

    assign keep        = (i_opcode <= 3'(pse_pkg::OP_END));
    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready && keep;
    assign pop         = o_tok_valid && i_tok_ready;
    assign o_tok_valid = (r_cnt != 2'd0);
    assign o_tok       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        // write slot is read pointer plus count
        if (push) r_q[r_rd ^ r_cnt[0]] <= '{opcode: i_opcode, value: i_value};
    end
endmodule
`default_nettype wire

/* rtl/pse_back.sv */
// Back part: stack memory, sequencer, shift-add multiplier and restoring divider.
// Depends on pse_pkg.
`default_nettype none
module pse_back #(
    parameter int STACK_DEPTH = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_tok_valid,
    output logic             o_tok_ready,
    input  pse_pkg::t_token  i_tok,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [63:0]      o_result_value,
    output logic             o_error_flag
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_EXEC = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_WB   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    logic [63:0] r_mem [STACK_DEPTH];
    logic [63:0] r_rdat;
    t_state      r_state;
    logic [CW-1:0] r_cnt;
    logic        r_err;
    logic [2:0]  r_op;
    logic [63:0] r_val, r_x, r_y, r_res;
    logic        r_neg, r_un;
    logic [7:0]  r_step;
    logic [127:0] r_acc;   // mul product / div numerator-quotient
    logic [64:0]  r_rem;
    logic [63:0] r_d;
    logic        r_ovf;
    logic [63:0] r_out;
    logic        r_oerr;

    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_dat;
    logic [63:0]   ux, uy, sum, dif;
    logic [64:0]   trial;

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    assign ux  = mag(r_x);
    assign uy  = mag(r_rdat);
    assign sum = r_x + r_rdat;
    assign dif = r_x - r_rdat;
    assign trial = {r_rem[63:0], r_acc[127]} - {1'b0, r_d};

    assign o_tok_ready    = (r_state == S_IDLE) && !o_valid;
    assign o_result_value = r_out;
    assign o_error_flag   = r_oerr;

    // read address: next-to-top in the first read cycle of a binary operator,
    // else the top entry; entry 0 while idle
    always_comb begin
        rd_addr = AW'(r_cnt - CW'(1));
        if (r_state == S_RD && !r_un && r_op != 3'(pse_pkg::OP_END))
            rd_addr = AW'(r_cnt - CW'(2));
        if (r_state == S_IDLE) rd_addr = '0;
    end

    always_ff @(posedge i_clk) begin
        r_rdat <= r_mem[rd_addr];
        if (mem_we) r_mem[wr_addr] <= wr_dat;
    end

    always_comb begin
        mem_we  = 1'b0;
        wr_addr = AW'(r_cnt);
        wr_dat  = r_val;
        if (r_state == S_EXEC && r_op == 3'(pse_pkg::OP_NUM)) mem_we = 1'b1;
        if (r_state == S_WB && !r_ovf) begin
            mem_we  = 1'b1;
            wr_addr = r_un ? '0 : AW'(r_cnt - CW'(2));
            wr_dat  = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_err   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_tok_valid && o_tok_ready) begin
                    r_op  <= i_tok.opcode;
                    r_val <= i_tok.value;
                    r_un  <= (i_tok.opcode == 3'(pse_pkg::OP_SUB)) && (r_cnt == CW'(1));
                    if (i_tok.opcode == 3'(pse_pkg::OP_END)) r_state <= S_RD;
                    else if (r_err) r_state <= S_IDLE;
                    else if (i_tok.opcode == 3'(pse_pkg::OP_NUM)) r_state <= S_EXEC;
                    else if (i_tok.opcode == 3'(pse_pkg::OP_SUB) && r_cnt == CW'(1))
                        r_state <= S_RD;
                    else if (r_cnt < CW'(2)) begin
                        r_err   <= 1'b1;
                        r_state <= S_IDLE;
                    end else r_state <= S_RD;
                end
                S_RD: begin
                    // left operand (or sole entry) is read here; r_rdat holds it in S_EXEC
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_x <= r_rdat;
                    unique case (r_op)
                        3'(pse_pkg::OP_NUM): begin
                            if (r_cnt >= CW'(STACK_DEPTH)) r_err <= 1'b1;
                            else r_cnt <= r_cnt + CW'(1);
                            r_state <= S_IDLE;
                        end
                        3'(pse_pkg::OP_END): begin
                            r_oerr <= r_err || r_cnt != CW'(1) ||
                                      (!r_rdat[63] && r_rdat >= pse_pkg::LIMIT_Q);
                            r_out  <= (r_err || r_cnt != CW'(1) ||
                                      (!r_rdat[63] && r_rdat >= pse_pkg::LIMIT_Q))
                                      ? 64'd0 : r_rdat;
                            o_valid <= 1'b1;
                            r_cnt   <= '0;
                            r_err   <= 1'b0;
                            r_state <= S_IDLE;
                        end
                        default: begin
                            if (r_un) begin
                                r_res   <= 64'd0 - r_rdat;
                                r_ovf   <= (r_rdat == pse_pkg::SIGN_BIT);
                                r_state <= S_WB;
                            end else r_state <= S_OUT;  // fetch right operand
                        end
                    endcase
                end
                S_OUT: begin
                    // r_x = left, r_rdat = right
                    r_neg  <= r_x[63] ^ r_rdat[63];
                    r_step <= '0;
                    unique case (r_op)
                        3'(pse_pkg::OP_ADD): begin
                            r_res <= sum;
                            r_ovf <= ~(r_x[63] ^ r_rdat[63]) & (r_x[63] ^ sum[63]);
                            r_state <= S_WB;
                        end
                        3'(pse_pkg::OP_SUB): begin
                            r_res <= dif;
                            r_ovf <= (r_x[63] ^ r_rdat[63]) & (r_x[63] ^ dif[63]);
                            r_state <= S_WB;
                        end
                        3'(pse_pkg::OP_MUL): begin
                            r_acc <= {64'd0, uy};
                            r_d   <= ux;
                            r_ovf <= 1'b0;
                            r_state <= S_MUL;
                        end
                        default: begin
                            r_acc <= {40'd0, ux, 24'd0};
                            r_rem <= '0;
                            r_d   <= uy;
                            r_ovf <= (r_rdat == 64'd0);
                            r_state <= S_DIV;
                        end
                    endcase
                end
                S_MUL: begin
                    // shift-add, one bit a cycle
                    r_acc <= {({1'b0, r_acc[127:64]} + (r_acc[0] ? {1'b0, r_d} : 65'd0)),
                              r_acc[63:1]};
                    r_step <= r_step + 8'd1;
                    if (r_step == 8'd63) r_state <= S_WB;
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (r_rem[63] || !trial[64]) begin
                        r_rem <= {1'b0, trial[63:0]};
                        r_acc <= {r_acc[126:0], 1'b1};
                    end else begin
                        r_rem <= {1'b0, r_rem[62:0], r_acc[127]};
                        r_acc <= {r_acc[126:0], 1'b0};
                    end
                    r_step <= r_step + 8'd1;
                    if (r_step == 8'd127) r_state <= S_WB;
                end
                S_WB: begin
                    if (r_op == 3'(pse_pkg::OP_MUL) || r_op == 3'(pse_pkg::OP_DIV)) begin
                        // apply sign to magnitude, then write on next visit
                        logic [63:0] m;
                        logic        bad;
                        m   = (r_op == 3'(pse_pkg::OP_MUL)) ? r_acc[87:24] : r_acc[63:0];
                        bad = r_ovf ||
                              ((r_op == 3'(pse_pkg::OP_MUL)) ? (r_acc[127:88] != '0)
                                                             : (r_acc[127:64] != '0));
                        bad = bad || (r_neg ? (m > pse_pkg::SIGN_BIT)
                                            : (m >= pse_pkg::SIGN_BIT));
                        r_ovf <= bad;
                        r_res <= r_neg ? (64'd0 - m) : m;
                        r_op  <= 3'(pse_pkg::OP_ADD);   // result ready, retire next cycle
                    end else begin
                        if (r_ovf) r_err <= 1'b1;
                        else if (!r_un) r_cnt <= r_cnt - CW'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/postfix_stack_evaluator_core.sv */
// Top level of the postfix stack evaluator: front queue plus back execution unit.
// Depends on pse_pkg, pse_front, pse_back.
//
//   channel | signals                                  | direction
//   token   | i_valid, o_ready, i_opcode, i_operand_value | in
//   result  | o_valid, i_ready, o_result_value, o_error_flag | out
//
// In the back, multiply runs one bit a cycle through the shift-add unit and
// divide one quotient bit a cycle through the restoring divider; after an
// error every token but end is taken and ignored. Tokens are registered in
// the front queue first. Opcodes 6 and 7 are dropped there.
// Synchronous active-low reset clears count, error and handshakes; stack memory
// is not cleared. A waiting result stalls the back; the front keeps two tokens.
`default_nettype none
module postfix_stack_evaluator_core #(
    parameter int STACK_DEPTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_opcode,
    input  wire  [63:0] i_operand_value,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [63:0] o_result_value,
    output logic        o_error_flag
);
    logic            tok_valid, tok_ready;
    pse_pkg::t_token tok;

    // hold tokens in the front queue; advance them as the back frees up
    pse_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_value(i_operand_value),
        .o_tok_valid(tok_valid), .i_tok_ready(tok_ready), .o_tok(tok)
    );

    pse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_tok_valid(tok_valid), .o_tok_ready(tok_ready), .i_tok(tok),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_value(o_result_value), .o_error_flag(o_error_flag)
    );
endmodule
`default_nettype wire

/* tb/postfix_stack_evaluator_core_test.sv */
// Self-checking bench for postfix_stack_evaluator_core: random postfix token streams with a
// bit-exact Q40.24 predictor and an ordered scoreboard of expected end-token results.
// Depends on pse_pkg and the RTL top level only.
`timescale 1ns / 100ps
module postfix_stack_evaluator_core_test;

    localparam int DEPTH = 32;
    localparam logic [63:0] ONE_Q = 64'h0000_0000_0100_0000;

    typedef struct {
        logic [2:0]  opcode;
        logic [63:0] value;
    } t_item;

    typedef struct {
        logic [63:0] value;
        logic        err;
    } t_outcome;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  in_opcode;
    logic [63:0] in_value;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] out_value;
    logic        out_err;

    // Pending tokens for the driver, expected results for the monitor.
    t_item    token_queue[$];
    t_outcome outcome_queue[$];

    // Predictor state.
    logic [63:0] eval_stack[DEPTH];
    int          eval_count;
    bit          eval_err;

    int  fail_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;

    // Input handshake seen at the last rising edge.
    bit  in_ready_s;

    postfix_stack_evaluator_core #(.STACK_DEPTH(DEPTH)) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_opcode        (in_opcode),
        .i_operand_value (in_value),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_result_value  (out_value),
        .o_error_flag    (out_err)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] mag64(logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    // Put the sign back on a magnitude; ok cleared when it does not fit.
    function automatic logic [63:0] signed_fit(logic [127:0] m, bit neg, output bit ok);
        ok = neg ? (m <= {64'd0, pse_pkg::SIGN_BIT}) : (m < {64'd0, pse_pkg::SIGN_BIT});
        return neg ? 64'd0 - m[63:0] : m[63:0];
    endfunction

    // Advance the predictor by one token; push an expectation on end.
    task automatic predict_token(t_item it);
        logic [63:0]  x, y, r;
        logic [127:0] wide;
        bit           ok;
        bit           neg;
        t_outcome     o;
        ok = 1'b1;
        r  = '0;
        if (it.opcode == pse_pkg::OP_END) begin
            o.err   = eval_err || eval_count != 1;
            o.value = '0;
            if (!o.err && !eval_stack[0][63] && eval_stack[0] >= pse_pkg::LIMIT_Q)
                o.err = 1'b1;
            if (!o.err) o.value = eval_stack[0];
            outcome_queue.push_back(o);
            eval_count = 0;
            eval_err   = 1'b0;
            return;
        end
        if (it.opcode > pse_pkg::OP_END || eval_err) return;
        if (it.opcode == pse_pkg::OP_NUM) begin
            if (eval_count >= DEPTH) eval_err = 1'b1;
            else eval_stack[eval_count++] = it.value;
            return;
        end
        if (it.opcode == pse_pkg::OP_SUB && eval_count == 1) begin
            if (eval_stack[0] == pse_pkg::SIGN_BIT) eval_err = 1'b1;
            else eval_stack[0] = 64'd0 - eval_stack[0];
            return;
        end
        if (eval_count < 2) begin
            eval_err = 1'b1;
            return;
        end
        y = eval_stack[eval_count-1];
        x = eval_stack[eval_count-2];
        neg = x[63] ^ y[63];
        case (pse_pkg::t_opcode'(it.opcode))
            pse_pkg::OP_ADD: begin
                r = x + y;
                ok = !(x[63] == y[63] && r[63] != x[63]);
            end
            pse_pkg::OP_SUB: begin
                r = x - y;
                ok = !(x[63] != y[63] && r[63] != x[63]);
            end
            pse_pkg::OP_MUL: begin
                wide = ({64'd0, mag64(x)} * {64'd0, mag64(y)}) >> 24;
                r = signed_fit(wide, neg, ok);
            end
            default: begin
                if (y == '0) ok = 1'b0;
                else begin
                    wide = ({64'd0, mag64(x)} << 24) / {64'd0, mag64(y)};
                    r = signed_fit(wide, neg, ok);
                end
            end
        endcase
        if (!ok) begin
            eval_err = 1'b1;
            return;
        end
        eval_count--;
        eval_stack[eval_count-1] = r;
    endtask

    task automatic queue_token(logic [2:0] op, logic [63:0] v);
        t_item it;
        it.opcode = op;
        it.value  = v;
        token_queue.push_back(it);
        predict_token(it);
    endtask

    function automatic logic [63:0] rand_q();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return v;
            1: return $signed(v) >>> 30;
            2: return $signed(v) >>> 40;
            3: return $signed(v) >>> $urandom_range(20, 63);
            4: return v[0] ? ONE_Q : '0;
            default: return $signed(v) >>> 36;
        endcase
    endfunction

    // Well-formed expression of a few operators, with a mangled one now and then.
    task automatic queue_expression();
        int depth;
        int n_ops;
        logic [2:0] op;
        depth = 0;
        n_ops = $urandom_range(0, 6);
        queue_token(pse_pkg::OP_NUM, rand_q());
        depth = 1;
        while (n_ops > 0) begin
            if (depth < 2 || ($urandom_range(0, 1) && depth < DEPTH)) begin
                queue_token(pse_pkg::OP_NUM, rand_q());
                depth++;
            end else begin
                op = 3'($urandom_range(pse_pkg::OP_ADD, pse_pkg::OP_DIV));
                queue_token(op, '0);
                depth--;
                n_ops--;
            end
        end
        if ($urandom_range(0, 9) == 0) queue_token(3'($urandom_range(0, 7)), rand_q());
        while (depth > 1 && $urandom_range(0, 7) != 0) begin
            queue_token(3'($urandom_range(pse_pkg::OP_ADD, pse_pkg::OP_DIV)), '0);
            depth--;
        end
        queue_token(pse_pkg::OP_END, '0);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Driver: present the head token, drop it once the transaction completes.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready_s) begin
                void'(token_queue.pop_front());
            end
            if (in_valid && !in_ready_s) begin
                // hold the offered token
            end else if (token_queue.size() > 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid  <= 1'b1;
                in_opcode <= token_queue[0].opcode;
                in_value  <= token_queue[0].value;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Handshake flags sampled at the rising edge.
    always @(posedge clk) begin
        in_ready_s <= in_valid && in_ready;
    end

    // Monitor: check each result transaction against the oldest expectation.
    always @(posedge clk) begin
        t_outcome o;
        if (rst_n && out_valid && out_ready) begin
            if (outcome_queue.size() == 0) begin
                report_mismatch("unexpected result", out_value, '0);
            end else begin
                o = outcome_queue.pop_front();
                if (out_value !== o.value) report_mismatch("result_value", out_value, o.value);
                if (out_err !== o.err) report_mismatch("error_flag", out_err, o.err);
            end
        end
    end

    // Receiver stall pattern, with a long hold-off counted here.
    always @(negedge clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic drain();
        while (token_queue.size() != 0 || in_valid) @(posedge clk);
        while (outcome_queue.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial begin
        int k;
        int pct_idle[4];
        int pct_stall[4];
        pct_idle  = '{0, 70, 0, 21};
        pct_stall = '{0, 0, 70, 21};
        in_valid = 1'b0; in_opcode = '0; in_value = '0;
        out_ready = 1'b0; fail_count = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
        eval_count = 0; eval_err = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every operator, each special case.
        queue_token(pse_pkg::OP_NUM, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_token(pse_pkg::OP_END, '0);
        queue_token(pse_pkg::OP_NUM, pse_pkg::SIGN_BIT); queue_token(pse_pkg::OP_END, '0);
        queue_token(pse_pkg::OP_NUM, pse_pkg::SIGN_BIT); queue_token(pse_pkg::OP_SUB, '0);
        queue_token(pse_pkg::OP_END, '0);
        queue_token(pse_pkg::OP_NUM, ONE_Q); queue_token(pse_pkg::OP_SUB, '0);
        queue_token(pse_pkg::OP_END, '0);
        queue_token(pse_pkg::OP_SUB, '0); queue_token(pse_pkg::OP_END, '0);
        queue_token(pse_pkg::OP_NUM, ONE_Q); queue_token(pse_pkg::OP_ADD, '0);
        queue_token(pse_pkg::OP_END, '0);
        queue_token(pse_pkg::OP_NUM, ONE_Q); queue_token(pse_pkg::OP_NUM, '0);
        queue_token(pse_pkg::OP_DIV, '0); queue_token(pse_pkg::OP_END, '0);
        queue_token(pse_pkg::OP_NUM, pse_pkg::LIMIT_Q); queue_token(pse_pkg::OP_END, '0);
        queue_token(pse_pkg::OP_NUM, pse_pkg::LIMIT_Q - 1); queue_token(pse_pkg::OP_END, '0);
        queue_token(pse_pkg::OP_NUM, 64'h0000_7FFF_0000_0000);
        queue_token(pse_pkg::OP_NUM, 64'h0000_7FFF_0000_0000);
        queue_token(pse_pkg::OP_MUL, '0); queue_token(pse_pkg::OP_END, '0);
        queue_token(3'd6, '0); queue_token(3'd7, '1);
        queue_token(pse_pkg::OP_END, '0);
        drain();

        // Overflow the stack, then a long receiver hold-off so the input stalls.
        for (k = 0; k <= DEPTH; k++) queue_token(pse_pkg::OP_NUM, rand_q());
        queue_token(pse_pkg::OP_END, '0);
        hold_off_cycles = 2000;
        for (k = 0; k < 40; k++) begin
            queue_token(pse_pkg::OP_NUM, rand_q()); queue_token(pse_pkg::OP_END, '0);
        end
        drain();

        for (k = 0; k < 4; k++) begin
            send_idle_pct  = pct_idle[k];
            recv_stall_pct = pct_stall[k];
            while (token_queue.size() < 310) queue_expression();
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        drain();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("FAILURE");
        $finish;
    end
endmodule
